// ===== sv/tcw_pkg.sv =====
`default_nettype none
package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int ADDR_W  = 11;
  localparam int COL_W   = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W   = $clog2(SCREEN_ROWS);
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = COLOR_W + CHAR_W;
  localparam int MODE_W  = 2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'd10;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_TAIL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PTR_FIRST_ROW,
    PTR_SECOND_ROW,
    PTR_LAST_ROW
  } ptr_sel_t;

  typedef struct packed {
    logic     take;
    logic     ptr_load;
    ptr_sel_t ptr_sel;
    logic     copy_step;
    logic     fill_step;
    logic     fill_blank;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic need_scroll;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/tcw_in_if.sv =====
`default_nettype none
interface tcw_in_if import tcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   char_code;
  logic [ADDR_W-1:0]   read_address;

  modport source (output valid, mode, char_code, read_address, input ready);
  modport sink   (input valid, mode, char_code, read_address, output ready);
endinterface
`default_nettype wire

// ===== sv/tcw_out_if.sv =====
`default_nettype none
interface tcw_out_if import tcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   cursor_position;
  logic [CELL_W-1:0]   cell_value;

  modport source (output valid, cursor_position, cell_value, input ready);
  modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface
`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
`default_nettype none
module tcw_ctrl import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_ready,
  input  wire dp_stat_t          stat,
  output ctrl_cmd_t              cmd
);

  state_t state_r, state_nxt;
  mode_t  mode;

  assign mode = mode_t'(in_mode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.ptr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_PUT:   state_nxt = stat.need_scroll ? ST_SCROLL : ST_DONE;
            MODE_CLEAR: state_nxt = ST_FILL;
            MODE_READ:  state_nxt = ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCROLL: begin
        if (stat.ptr_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: state_nxt = ST_FILL;
      ST_FILL: begin
        if (stat.ptr_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.ptr_sel    = PTR_FIRST_ROW;
    unique case (state_r)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && mode == MODE_PUT && stat.need_scroll) begin
          cmd.ptr_load = 1'b1;
          cmd.ptr_sel  = PTR_SECOND_ROW;
        end
        if (in_valid && mode == MODE_CLEAR) begin
          cmd.ptr_load = 1'b1;
          cmd.ptr_sel  = PTR_FIRST_ROW;
        end
      end
      ST_SCROLL: begin
        cmd.copy_step = 1'b1;
      end
      ST_TAIL: begin
        // last copied cell lands this cycle; aim at the bottom row
        cmd.ptr_load = 1'b1;
        cmd.ptr_sel  = PTR_LAST_ROW;
      end
      ST_FILL: begin
        cmd.fill_step  = 1'b1;
        cmd.fill_blank = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tcw_dp.sv =====
`default_nettype none
module tcw_dp import tcw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  input  wire logic [COLOR_W-1:0] text_color,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [CHAR_W-1:0]  in_char_code,
  input  wire logic [ADDR_W-1:0]  in_read_address,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ADDR_W-1:0]       out_cursor_position,
  output logic [CELL_W-1:0]       out_cell_value
);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [ADDR_W-1:0] lin_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [CELL_W-1:0] rd_q_r;
  logic              cell_ok_r;
  logic              wb_en_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] cur_pos_r;
  logic [CELL_W-1:0] cell_val_r;

  logic              is_put, is_read, is_nl, wrap, put_write, rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr, ptr_base;
  logic [CELL_W-1:0] wr_data;

  assign is_put  = mode_t'(in_mode) == MODE_PUT;
  assign is_read = (mode_t'(in_mode) == MODE_READ) && (in_read_address <= LAST_CELL);
  assign is_nl   = in_char_code == NEWLINE_CODE;
  assign wrap    = is_nl || (col_r == LAST_COL);
  assign put_write = cmd.take && is_put && !is_nl;

  assign stat.ptr_last    = ptr_r == LAST_CELL;
  assign stat.need_scroll = wrap && (row_r == LAST_ROW);
  assign stat.out_free    = !out_valid_r || out_ready;

  // cursor moves when the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      lin_r <= '0;
    end else if (cmd.take && is_put) begin
      if (!wrap) begin
        col_r <= col_r + COL_W'(1);
        lin_r <= lin_r + ADDR_W'(1);
      end else begin
        col_r <= '0;
        if (row_r == LAST_ROW) begin
          lin_r <= lin_r - ADDR_W'(col_r);
        end else begin
          row_r <= row_r + ROW_W'(1);
          lin_r <= lin_r - ADDR_W'(col_r) + ROW_STRIDE;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.ptr_sel)
      PTR_FIRST_ROW:  ptr_base = '0;
      PTR_SECOND_ROW: ptr_base = ROW_STRIDE;
      PTR_LAST_ROW:   ptr_base = LAST_ROW_BASE;
      default:        ptr_base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      wb_en_r <= 1'b0;
    end else begin
      wb_en_r <= cmd.copy_step;
      if (cmd.ptr_load) begin
        ptr_r <= ptr_base;
      end else if (cmd.copy_step || cmd.fill_step) begin
        ptr_r <= ptr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= ptr_r - ROW_STRIDE;
  end

  // one write port: put, scroll write-back and fill never meet
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = cmd.fill_blank ? {text_color, {CHAR_W{1'b0}}} : '0;
    priority if (put_write) begin
      wr_en   = 1'b1;
      wr_addr = lin_r;
      wr_data = {text_color, in_char_code};
    end else if (wb_en_r) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr_r;
      wr_data = rd_q_r;
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
    end
  end

  assign rd_en   = (cmd.take && is_read) || cmd.copy_step;
  assign rd_addr = cmd.copy_step ? ptr_r : in_read_address;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cell_ok_r <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cur_pos_r  <= lin_r;
      cell_val_r <= cell_ok_r ? rd_q_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = cur_pos_r;
  assign out_cell_value      = cell_val_r;

endmodule
`default_nettype wire

// ===== sv/text_console_writer_core.sv =====
// Channel  | Direction | Handshake     | Payload
// in_chan  | sink      | valid / ready | mode, char_code, read_address
// out_chan | source    | valid / ready | cursor_position, cell_value
// cfg_*    | APB slave | psel/penable  | text_color at byte address 0
//
// Put, newline without scroll, read and idle codes go straight from accept to result.
// A scroll walks the screen store once: it copies 1920 cells up one row, then blanks
// the 80 bottom-row cells; a clear writes all 2000 cells, one per cycle over the single
// write port. After reset all 2000 cells are zeroed before in_chan.ready rises.
// One item is at work at a time; a finished result waits in the output register
// while the next item is taken.
`default_nettype none
module text_console_writer_core import tcw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  tcw_in_if.sink                  in_chan,
  tcw_out_if.source               out_chan,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output logic      [PDATA_W-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  logic [COLOR_W-1:0] text_color_r;
  logic               reg_hit;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  assign cfg_pready = 1'b1;
  assign reg_hit    = cfg_paddr[PADDR_W-1:2] == REG_TEXT_COLOR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      text_color_r <= cfg_pwdata[COLOR_W-1:0];
    end
  end

  assign cfg_prdata = reg_hit ? PDATA_W'(text_color_r) : '0;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .text_color          (text_color_r),
    .in_mode             (in_chan.mode),
    .in_char_code        (in_chan.char_code),
    .in_read_address     (in_chan.read_address),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_cursor_position (out_chan.cursor_position),
    .out_cell_value      (out_chan.cell_value)
  );

endmodule
`default_nettype wire

// ===== sv/tcw_checker.sv =====
`default_nettype none
module tcw_checker import tcw_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] out_cursor_position,
  input wire logic              cfg_pready
);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

  // one item at a time: nothing is taken in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still at work");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_position <= LAST_CELL)
    else $error("cursor position off screen");

  // both channels are quiet straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channel active straight after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_position))
    else $error("stalled result changed");

  a_pready_high: assert property (@(posedge clk) cfg_pready)
    else $error("configuration port inserted a wait");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_cursor_position (out_chan.cursor_position),
  .cfg_pready          (cfg_pready)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import tcw_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_IDLE_CODE  = 2'd3;
  localparam logic [PADDR_W-1:0] TEXT_COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};
  localparam int PHASE_ITEMS     = 260;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RUN_LIMIT_NS    = 40_000_000;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_value;
  } console_report_t;

  class console_scoreboard;
    logic [CELL_W-1:0]  cells [CELL_COUNT];
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] color;
    console_report_t    expected_reports [$];
    int mismatches, checked, chars, newlines, scrolls, clears, reads;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row = '0;
      col = '0;
      color = TEXT_COLOR_RESET;
      mismatches = 0;
      checked = 0;
      chars = 0;
      newlines = 0;
      scrolls = 0;
      clears = 0;
      reads = 0;
    endfunction

    function void set_color(input logic [COLOR_W-1:0] c);
      color = c;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function int cursor_index();
      return int'(row) * SCREEN_COLUMNS + int'(col);
    endfunction

    function void blank_cells(input int first, input int count);
      for (int i = first; i < first + count; i++) cells[i] = {color, {CHAR_W{1'b0}}};
    endfunction

    // Drop to the next row; below the last row, shift the screen up one row.
    function void next_line();
      col = '0;
      if (int'(row) == SCREEN_ROWS - 1) begin
        for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
          cells[i] = cells[i + SCREEN_COLUMNS];
        blank_cells(CELL_COUNT - SCREEN_COLUMNS, SCREEN_COLUMNS);
        scrolls++;
      end else begin
        row = row + 1'b1;
      end
    endfunction

    function void note_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                            input logic [ADDR_W-1:0] addr);
      logic [CELL_W-1:0] cell_word;
      cell_word = '0;
      case (mode)
        MODE_PUT: begin
          if (ch == NEWLINE_CODE) begin
            newlines++;
            next_line();
          end else begin
            chars++;
            cells[cursor_index()] = {color, ch};
            if (int'(col) == SCREEN_COLUMNS - 1) next_line();
            else col = col + 1'b1;
          end
        end
        MODE_CLEAR: begin
          clears++;
          blank_cells(0, CELL_COUNT);
        end
        MODE_READ: begin
          reads++;
          if (int'(addr) < CELL_COUNT) cell_word = cells[addr];
        end
        default: ;
      endcase
      expected_reports.push_back('{ADDR_W'(cursor_index()), cell_word});
    endfunction

    function void check_result(input logic [ADDR_W-1:0] cursor,
                               input logic [CELL_W-1:0] cell_word);
      console_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected: cursor_position %0d cell_value %h",
                 $time, cursor, cell_word);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      if (cursor !== want.cursor_position) begin
        $display("%0t: cursor_position expected %0d, got %0d",
                 $time, want.cursor_position, cursor);
        mismatches++;
      end
      if (cell_word !== want.cell_value) begin
        $display("%0t: cell_value expected %h, got %h", $time, want.cell_value, cell_word);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic               cfg_psel, cfg_penable, cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;
  int items_sent         = 0;
  int cfg_errors         = 0;

  console_scoreboard sb = new();

  tcw_in_if  in_bus ();
  tcw_out_if out_bus ();

  text_console_writer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
      sb.note_item(in_bus.mode, in_bus.char_code, in_bus.read_address);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_result(out_bus.cursor_position, out_bus.cell_value);
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (int'($urandom_range(0, 99)) >= receiver_stall_pct);
      end
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 4) != 0) return ADDR_W'($urandom_range(0, CELL_COUNT - 1));
    return ADDR_W'($urandom_range(CELL_COUNT, (1 << ADDR_W) - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    if (c == NEWLINE_CODE) c = ~c;
    return c;
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr);
    while (int'($urandom_range(0, 99)) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= mode;
    in_bus.char_code    <= ch;
    in_bus.read_address <= addr;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // A run of non-newline characters, mostly ended by a newline; long runs wrap.
  task automatic type_line();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) len = $urandom_range(0, 30);
    else if (pick < 9) len = $urandom_range(70, 85);
    else len = $urandom_range(150, 170);
    for (int i = 0; i < len; i++) send_item(MODE_PUT, text_char(), pick_address());
    if ($urandom_range(0, 3) != 0) send_item(MODE_PUT, NEWLINE_CODE, pick_address());
  endtask

  task automatic run_random_phase(input int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        type_line();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4))
          send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)), pick_address());
      end else if (pick < 88) begin
        send_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)), pick_address());
      end else if (pick < 94) begin
        send_item(MODE_IDLE_CODE, CHAR_W'($urandom_range(0, 255)), pick_address());
      end else begin
        send_item(MODE_PUT, CHAR_W'($urandom_range(0, 255)), pick_address());
      end
    end
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_text_color();
    logic [PDATA_W-1:0] got;
    apb_read(TEXT_COLOR_ADDR, got);
    if (got !== PDATA_W'(sb.color)) begin
      $display("%0t: text_color read back expected %h, got %h", $time, sb.color, got);
      cfg_errors++;
    end
  endtask

  // Let every expected item drain, then give the block time to settle.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_color(input logic [COLOR_W-1:0] c);
    wait_idle();
    apb_write(TEXT_COLOR_ADDR, PDATA_W'(c));
    sb.set_color(c);
    @(posedge clk);
    check_text_color();
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.mode         <= MODE_PUT;
    in_bus.char_code    <= '0;
    in_bus.read_address <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_text_color();

    // Directed: cleared screen, reads off the end, extreme characters, newline,
    // the unused mode, a clear that keeps the cursor.
    send_item(MODE_READ, 8'h00, '0);
    send_item(MODE_READ, 8'hFF, ADDR_W'(CELL_COUNT - 1));
    send_item(MODE_READ, 8'h00, '1);
    send_item(MODE_PUT, 8'h00, '1);
    send_item(MODE_PUT, 8'hFF, '0);
    send_item(MODE_PUT, 8'h41, ADDR_W'(CELL_COUNT));
    send_item(MODE_PUT, NEWLINE_CODE, '0);
    send_item(MODE_IDLE_CODE, 8'hFF, '1);
    send_item(MODE_READ, 8'h00, ADDR_W'(0));
    send_item(MODE_READ, 8'h00, ADDR_W'(1));
    send_item(MODE_READ, 8'h00, ADDR_W'(2));
    send_item(MODE_READ, 8'h00, ADDR_W'(SCREEN_COLUMNS));
    send_item(MODE_CLEAR, 8'h5A, '1);
    send_item(MODE_READ, 8'h00, ADDR_W'(1));
    send_item(MODE_PUT, 8'h7F, '0);
    send_item(MODE_PUT, NEWLINE_CODE, '0);
    send_item(MODE_READ, 8'h00, ADDR_W'(SCREEN_COLUMNS + 1));
    send_item(MODE_READ, 8'h00, ADDR_W'(CELL_COUNT));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_text_color(8'h00);
        1: set_text_color(8'hFF);
        2: set_text_color(COLOR_W'($urandom_range(1, 254)));
        default: set_text_color(COLOR_W'($urandom_range(0, 255)));
      endcase
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 58;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 58;
        end
        default: begin
          sender_idle_pct = 21;
          receiver_stall_pct = 21;
        end
      endcase
      // Hold results back while items keep coming, so the input side backs up.
      if (phase == 0 || phase == 3) hold_requests++;
      run_random_phase(items_sent + PHASE_ITEMS);
    end

    wait_idle();
    $display("Sent %0d items: %0d characters, %0d newlines, %0d reads, %0d clears",
             items_sent, sb.chars, sb.newlines, sb.reads, sb.clears);
    $display("Screen scrolled %0d times; %0d results compared", sb.scrolls, sb.checked);
    if (sb.mismatches == 0 && cfg_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
